FILE: sv/ring_buffer_position_list_macros.svh
// ----------------------------------------------------------------------------
// Ring buffer position list: assertion macros
// Shared property forms for the port checker of the list block.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_POSITION_LIST_MACROS_SVH
`define RING_BUFFER_POSITION_LIST_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBPL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBPL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rbpl_pkg.sv
// ----------------------------------------------------------------------------
// Ring buffer position list: package
// Request codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbpl_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FETCH,
    ST_MOVE,
    ST_PLACE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic fetch;
    logic move;
    logic scan;
    logic place;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    legal;
    logic    remain_zero;
    logic    pend;
    logic    match;
  } ctrl_stat_t;

endpackage

`default_nettype wire

FILE: sv/ring_buffer_position_list.sv
// ----------------------------------------------------------------------------
// Ring buffer position list: top level
// Ordered list of signed words in a circular store with head and fill.
// ----------------------------------------------------------------------------
// A request (opcode, position, item_value) is taken at a rising edge where
// start is high and busy is low. Busy stays high until the single result has
// been shown; done is high for exactly one cycle with ok, data and count
// valid in that cycle, and the transfer completes at the edge ending it.
// A request passes setup, then its own states, then the result state: get
// passes fetch; clear and rejected requests pass nothing more; insert
// moves words, then places the new one; delete fetches, then moves words.
// The shorter side of the list is moved, at most CAPACITY/2 words; locate
// scans from the front up to the first match, or over the whole fill.
// The store has one write and one registered read port; moves and scans
// stream one word per cycle through that port pair, which sets the rate.
// One request is in progress at a time. Reset empties the list (head and
// fill to zero); stored words are left as they are. The receiver cannot
// stall, so a result is never held back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ring_buffer_position_list #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [6:0]         position,
  input  logic signed [31:0] item_value,
  output logic               done,
  output logic               ok,
  output logic signed [31:0] data,
  output logic [6:0]         count
);
  import rbpl_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  rbpl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  rbpl_datapath #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .opcode     (opcode),
    .position   (position),
    .item_value (item_value),
    .ok         (ok),
    .data       (data),
    .count      (count)
  );

endmodule

`default_nettype wire

FILE: sv/rbpl_ctrl.sv
// ----------------------------------------------------------------------------
// Ring buffer position list: controller
// Sequences setup, word moves, scans and the result strobe for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbpl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  rbpl_pkg::ctrl_stat_t stat,
  output rbpl_pkg::ctrl_cmd_t  cmd,
  output logic                busy,
  output logic                done
);
  import rbpl_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (!stat.legal) begin
          state_next = ST_RESULT;
        end else begin
          unique case (stat.op)
            OP_INSERT: state_next = ST_MOVE;
            OP_DELETE: state_next = ST_FETCH;
            OP_GET:    state_next = ST_FETCH;
            OP_LOCATE: state_next = ST_SCAN;
            default:   state_next = ST_RESULT;
          endcase
        end
      end
      ST_FETCH: begin
        state_next = (stat.op == OP_DELETE) ? ST_MOVE : ST_RESULT;
      end
      ST_MOVE: begin
        if (stat.remain_zero) begin
          state_next = (stat.op == OP_INSERT) ? ST_PLACE : ST_RESULT;
        end
      end
      ST_PLACE: begin
        state_next = ST_RESULT;
      end
      ST_SCAN: begin
        if (stat.match || (stat.remain_zero && !stat.pend)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.load  = (state == ST_IDLE) && start;
    cmd.setup = (state == ST_SETUP);
    cmd.fetch = (state == ST_FETCH);
    cmd.move  = (state == ST_MOVE);
    cmd.scan  = (state == ST_SCAN);
    cmd.place = (state == ST_PLACE);
    busy      = (state != ST_IDLE);
    done      = (state == ST_RESULT);
  end

endmodule

`default_nettype wire

FILE: sv/rbpl_datapath.sv
// ----------------------------------------------------------------------------
// Ring buffer position list: datapath
// Circular word store, head and fill registers, walk pointers and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rbpl_datapath #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rbpl_pkg::ctrl_cmd_t  cmd,
  output rbpl_pkg::ctrl_stat_t stat,
  input  logic [2:0]           opcode,
  input  logic [6:0]           position,
  input  logic signed [31:0]   item_value,
  output logic                 ok,
  output logic signed [31:0]   data,
  output logic [6:0]           count
);
  import rbpl_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > 7) ? FW : 7;
  localparam int SW = CW + 1;

  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
    return (p == IW'(CAPACITY - 1)) ? '0 : p + IW'(1);
  endfunction

  function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
    return (p == '0) ? IW'(CAPACITY - 1) : p - IW'(1);
  endfunction

  logic [WORD_BITS-1:0] mem [CAPACITY];
  logic [WORD_BITS-1:0] rd_data;
  logic [IW-1:0]        rd_addr;
  logic                 we;
  logic [IW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic [IW-1:0]        head;
  logic [IW-1:0]        head_next;
  logic [FW-1:0]        fill;
  logic [FW-1:0]        fill_next;

  opcode_t              op_q;
  logic [6:0]           pos_q;
  logic [WORD_BITS-1:0] word_q;

  logic [IW-1:0]        rd_ptr;
  logic [IW-1:0]        rd_ptr_next;
  logic [IW-1:0]        wr_ptr;
  logic [IW-1:0]        wr_ptr_next;
  logic [IW-1:0]        place_ptr;
  logic [IW-1:0]        place_ptr_next;
  logic [FW-1:0]        remain;
  logic [FW-1:0]        remain_next;
  logic                 up;
  logic                 up_next;
  logic                 pend;
  logic [FW-1:0]        lidx;

  logic                 ok_q;
  logic [31:0]          data_q;

  logic [CW-1:0]        pos_c;
  logic [CW-1:0]        fill_c;
  logic [IW-1:0]        slot_p;
  logic [IW-1:0]        slot_last;
  logic [IW-1:0]        slot_fill;
  logic                 front;
  logic                 legal;
  logic                 match;
  logic [63:0]          wide_in;
  logic [63:0]          rd_wide;

  assign pos_c     = CW'(pos_q);
  assign fill_c    = CW'(fill);
  assign slot_p    = wrap_add(head, pos_c);
  assign slot_last = wrap_add(head, fill_c - CW'(1));
  assign slot_fill = wrap_add(head, fill_c);
  assign front     = pos_c < (fill_c >> 1);
  assign match     = pend && (rd_data == word_q);
  assign wide_in   = {{32{item_value[31]}}, item_value};
  assign rd_wide   = 64'(rd_data);

  always_comb begin
    unique case (op_q)
      OP_INSERT: legal = (pos_c <= fill_c) && (fill_c < CW'(CAPACITY));
      OP_DELETE: legal = pos_c < fill_c;
      OP_GET:    legal = pos_c < fill_c;
      OP_LOCATE: legal = fill_c != '0;
      OP_CLEAR:  legal = 1'b1;
      default:   legal = 1'b0;
    endcase
  end

  assign rd_addr = cmd.setup ? slot_p : rd_ptr;
  assign we      = (cmd.move && pend) || cmd.place;
  assign wr_addr = cmd.place ? place_ptr : wr_ptr;
  assign wr_data = cmd.place ? word_q : rd_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    head_next = head;
    fill_next = fill;
    if (cmd.setup && legal) begin
      unique case (op_q)
        OP_INSERT: begin
          fill_next = fill + FW'(1);
          if (front) begin
            head_next = ptr_dec(head);
          end
        end
        OP_DELETE: begin
          fill_next = fill - FW'(1);
          if (front) begin
            head_next = ptr_inc(head);
          end
        end
        OP_CLEAR: begin
          head_next = '0;
          fill_next = '0;
        end
        default: begin
          head_next = head;
        end
      endcase
    end
  end

  always_comb begin
    rd_ptr_next    = rd_ptr;
    wr_ptr_next    = wr_ptr;
    place_ptr_next = place_ptr;
    remain_next    = remain;
    up_next        = up;
    if (cmd.setup) begin
      rd_ptr_next    = head;
      wr_ptr_next    = slot_p;
      place_ptr_next = slot_p;
      remain_next    = '0;
      up_next        = 1'b1;
      unique case (op_q)
        OP_INSERT: begin
          if (front) begin
            wr_ptr_next    = ptr_dec(head);
            remain_next    = FW'(pos_c);
            place_ptr_next = ptr_dec(slot_p);
          end else begin
            rd_ptr_next = slot_last;
            wr_ptr_next = slot_fill;
            remain_next = FW'(fill_c - pos_c);
            up_next     = 1'b0;
          end
        end
        OP_DELETE: begin
          if (front) begin
            rd_ptr_next = ptr_dec(slot_p);
            remain_next = FW'(pos_c);
            up_next     = 1'b0;
          end else begin
            rd_ptr_next = ptr_inc(slot_p);
            remain_next = FW'(fill_c - pos_c - CW'(1));
          end
        end
        OP_LOCATE: begin
          remain_next = fill;
        end
        default: begin
          remain_next = '0;
        end
      endcase
    end else if (cmd.move || cmd.scan) begin
      if (remain != '0) begin
        rd_ptr_next = up ? ptr_inc(rd_ptr) : ptr_dec(rd_ptr);
        remain_next = remain - FW'(1);
      end
      if (cmd.move && pend) begin
        wr_ptr_next = up ? ptr_inc(wr_ptr) : ptr_dec(wr_ptr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
      pend <= 1'b0;
    end else begin
      head <= head_next;
      fill <= fill_next;
      pend <= (cmd.move || cmd.scan) && (remain != '0);
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr    <= rd_ptr_next;
    wr_ptr    <= wr_ptr_next;
    place_ptr <= place_ptr_next;
    remain    <= remain_next;
    up        <= up_next;
    if (cmd.load) begin
      op_q   <= opcode_t'(opcode);
      pos_q  <= position;
      word_q <= wide_in[WORD_BITS-1:0];
    end
    if (cmd.setup) begin
      ok_q   <= legal && (op_q != OP_LOCATE);
      data_q <= '0;
      lidx   <= '0;
    end else if (cmd.fetch) begin
      data_q <= rd_wide[31:0];
    end else if (cmd.scan && pend) begin
      lidx <= lidx + FW'(1);
      if (match) begin
        ok_q   <= 1'b1;
        data_q <= 32'(lidx);
      end
    end
  end

  always_comb begin
    stat             = '0;
    stat.op          = op_q;
    stat.legal       = legal;
    stat.remain_zero = (remain == '0);
    stat.pend        = pend;
    stat.match       = match;
  end

  assign ok    = ok_q;
  assign data  = data_q;
  assign count = fill_c[6:0];

endmodule

`default_nettype wire

FILE: sv/rbpl_checker.sv
// ----------------------------------------------------------------------------
// Ring buffer position list: port checker
// Checks request and result sequencing as seen on the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ring_buffer_position_list_macros.svh"

module rbpl_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [6:0] count
);

  `RBPL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `RBPL_ASSERT_SAME(a_done_busy, done, busy, "result shown while not busy")
  `RBPL_ASSERT_NEXT(a_done_release, done, !busy && !done, "busy or done held after result")
  `RBPL_ASSERT_NEXT(a_idle_count, !busy, $stable(count), "count changed while idle")

endmodule

bind ring_buffer_position_list rbpl_checker u_rbpl_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .count (count)
);

`default_nettype wire

FILE: sim/rbpl_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer position list: result checker
// Watches the request and result ports of the list block. It keeps its own
// copy of the circular store, head and fill, and works out the expected
// result of every accepted request. Each result strobe is compared field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------

module rbpl_list_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         opcode,
  input  logic [6:0]         position,
  input  logic signed [31:0] item_value,
  input  logic               done,
  input  logic               ok,
  input  logic signed [31:0] data,
  input  logic [6:0]         count,
  output int                 errors,
  output int                 pending,
  output logic [6:0]         fill_level
);
  import rbpl_pkg::*;

  localparam int LIST_DEPTH = 64;

  typedef struct {
    logic               ok;
    logic signed [31:0] data;
    logic [6:0]         count;
  } list_result_t;

  logic signed [31:0] ring_words [LIST_DEPTH];
  logic [5:0]         front_idx;
  logic [6:0]         list_len;
  list_result_t       awaited_q [$];
  list_result_t       oldest;
  list_result_t       fresh;

  initial begin
    errors     = 0;
    pending    = 0;
    fill_level = '0;
    front_idx  = '0;
    list_len   = '0;
  end

  task automatic report(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [5:0] ring_slot(int logical);
    return front_idx + logical[5:0];
  endfunction

  function automatic list_result_t apply_request(logic [2:0] op, logic [6:0] pos,
                                                 logic signed [31:0] val);
    list_result_t res;
    int i;
    res.ok   = 1'b0;
    res.data = '0;
    case (op)
      OP_INSERT: begin
        if (pos <= list_len && list_len < LIST_DEPTH) begin
          if (pos >= list_len / 2) begin
            for (i = int'(list_len); i > int'(pos); i--)
              ring_words[ring_slot(i)] = ring_words[ring_slot(i - 1)];
          end else begin
            front_idx = front_idx - 6'd1;
            for (i = 0; i < int'(pos); i++)
              ring_words[ring_slot(i)] = ring_words[ring_slot(i + 1)];
          end
          ring_words[ring_slot(int'(pos))] = val;
          list_len = list_len + 7'd1;
          res.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos < list_len) begin
          res.data = ring_words[ring_slot(int'(pos))];
          if (pos >= list_len / 2) begin
            for (i = int'(pos); i + 1 < int'(list_len); i++)
              ring_words[ring_slot(i)] = ring_words[ring_slot(i + 1)];
          end else begin
            for (i = int'(pos); i > 0; i--)
              ring_words[ring_slot(i)] = ring_words[ring_slot(i - 1)];
            front_idx = front_idx + 6'd1;
          end
          list_len = list_len - 7'd1;
          res.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (pos < list_len) begin
          res.data = ring_words[ring_slot(int'(pos))];
          res.ok   = 1'b1;
        end
      end
      OP_LOCATE: begin
        for (i = 0; i < int'(list_len) && !res.ok; i++) begin
          if (ring_words[ring_slot(i)] == val) begin
            res.data = i;
            res.ok   = 1'b1;
          end
        end
      end
      OP_CLEAR: begin
        front_idx = '0;
        list_len  = '0;
        res.ok    = 1'b1;
      end
      default: ;
    endcase
    res.count = list_len;
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      front_idx = '0;
      list_len  = '0;
      awaited_q.delete();
    end else begin
      if (done) begin
        if (awaited_q.size() == 0) begin
          report($sformatf("result with none awaited: ok=%0b data=%0d count=%0d",
                           ok, data, count));
        end else begin
          oldest = awaited_q.pop_front();
          if (ok !== oldest.ok)
            report($sformatf("ok got %0b, wanted %0b", ok, oldest.ok));
          if (data !== oldest.data)
            report($sformatf("data got %0d, wanted %0d", data, oldest.data));
          if (count !== oldest.count)
            report($sformatf("count got %0d, wanted %0d", count, oldest.count));
        end
      end
      if (start && !busy) begin
        fresh = apply_request(opcode, position, item_value);
        awaited_q.push_back(fresh);
      end
    end
    pending    <= awaited_q.size();
    fill_level <= list_len;
  end

endmodule

FILE: sim/tb_ring_buffer_position_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring buffer position list: testbench top
// Drives requests into the list block: a short directed run over empty and
// out-of-range cases, then phases of random requests that grow, shrink,
// fill and mix the list, with random gaps between transfers. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_ring_buffer_position_list;
  import rbpl_pkg::*;

  localparam int         TOTAL_ITEMS  = 600;
  localparam int         PHASE_ITEMS  = 40;
  localparam int         LIST_DEPTH   = 64;
  localparam int         TAIL_CYCLES  = 80;
  localparam longint     TIMEOUT_NS   = 2_000_000;
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         opcode;
  logic [6:0]         position;
  logic signed [31:0] item_value;
  logic               done;
  logic               ok;
  logic signed [31:0] data;
  logic [6:0]         count;
  int                 errors;
  int                 pending;
  logic [6:0]         fill_level;

  int                 sent;
  bit                 quiet;

  always #2 clk = ~clk;

  ring_buffer_position_list dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .position   (position),
    .item_value (item_value),
    .done       (done),
    .ok         (ok),
    .data       (data),
    .count      (count)
  );

  rbpl_list_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .position   (position),
    .item_value (item_value),
    .done       (done),
    .ok         (ok),
    .data       (data),
    .count      (count),
    .errors     (errors),
    .pending    (pending),
    .fill_level (fill_level)
  );

  // A small pool of values makes locate hits and repeated words common.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4,
      5:       return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(logic [2:0] op, logic [6:0] pos, logic [31:0] val);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    opcode     <= op;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic random_request(int mode);
    int roll;
    int lvl;
    int ins_pct;
    int del_pct;
    logic [6:0] pos;
    roll = $urandom_range(0, 99);
    lvl  = fill_level;
    case (mode)
      0:       begin ins_pct = 60; del_pct = 15; end
      1:       begin ins_pct = 20; del_pct = 50; end
      default: begin ins_pct = 35; del_pct = 30; end
    endcase
    if ($urandom_range(0, 9) == 0)
      pos = 7'(lvl + $urandom_range(0, 3));
    else if (lvl == 0)
      pos = '0;
    else
      pos = 7'($urandom_range(0, lvl - 1));
    if (roll < 8) begin
      issue(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)), $urandom);
    end else if (roll < 10) begin
      issue(OP_CLEAR, 7'($urandom_range(0, 127)), $urandom);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < ins_pct)
        issue(OP_INSERT, $urandom_range(0, 9) == 0 ? pos : 7'($urandom_range(0, lvl)),
              pick_value());
      else if (roll < ins_pct + del_pct)
        issue(OP_DELETE, pos, $urandom);
      else if (roll < ins_pct + del_pct + (100 - ins_pct - del_pct) / 2)
        issue(OP_GET, pos, $urandom);
      else
        issue(OP_LOCATE, 7'($urandom_range(0, 127)), pick_value());
    end
  endtask

  initial begin
    int mode;
    int guard;
    logic [2:0] op;
    rst        <= 1'b1;
    start      <= 1'b0;
    opcode     <= OP_INSERT;
    position   <= '0;
    item_value <= '0;
    sent  = 0;
    quiet = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, past-the-end insert, extremes, both move sides.
    issue(OP_GET,    7'd0,   32'd0);
    issue(OP_DELETE, 7'd0,   32'd0);
    issue(OP_LOCATE, 7'd0,   32'd5);
    issue(OP_INSERT, 7'd1,   32'd1);
    issue(OP_INSERT, 7'd0,   32'h7fff_ffff);
    issue(OP_INSERT, 7'd1,   32'h8000_0000);
    issue(OP_INSERT, 7'd1,   32'd0);
    issue(OP_INSERT, 7'd0,   32'hffff_ffff);
    issue(OP_INSERT, 7'd4,   32'h5555_aaaa);
    issue(OP_GET,    7'd4,   32'd0);
    issue(OP_GET,    7'd5,   32'd0);
    issue(OP_GET,    7'd127, 32'd0);
    issue(OP_LOCATE, 7'd0,   32'h8000_0000);
    issue(OP_LOCATE, 7'd0,   32'h0001_2345);
    for (op = OP_SPARE_LO; op <= OP_SPARE_HI && op >= OP_SPARE_LO; op++)
      issue(op, 7'd127, 32'haaaa_5555);
    issue(OP_DELETE, 7'd4,   32'd0);
    issue(OP_DELETE, 7'd0,   32'd0);
    issue(OP_DELETE, 7'd1,   32'd0);
    issue(OP_DELETE, 7'd2,   32'd0);
    issue(OP_CLEAR,  7'd0,   32'd0);
    issue(OP_GET,    7'd0,   32'd0);
    issue(OP_INSERT, 7'd0,   32'd42);

    while (sent < TOTAL_ITEMS) begin
      drain();
      quiet = ($urandom_range(0, 3) == 0);
      mode  = $urandom_range(0, 3);
      if (mode == 3) begin
        // Fill the store to capacity, then push against the full limit.
        guard = 0;
        while (fill_level < LIST_DEPTH && guard < 80) begin
          issue(OP_INSERT, 7'($urandom_range(0, fill_level)), pick_value());
          guard++;
        end
        repeat (4) issue(OP_INSERT, 7'($urandom_range(0, LIST_DEPTH)), pick_value());
        repeat (4) issue(OP_GET, 7'($urandom_range(0, LIST_DEPTH)), $urandom);
        issue(OP_LOCATE, 7'd0, pick_value());
      end else begin
        repeat (PHASE_ITEMS) random_request(mode);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[%0t] timeout with %0d results outstanding", $time, pending);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/rbpl_pkg.sv
sv/rbpl_ctrl.sv
sv/rbpl_datapath.sv
sv/ring_buffer_position_list.sv
sv/rbpl_checker.sv
sim/rbpl_list_checker.sv
sim/tb_ring_buffer_position_list.sv
